// ----- design/bcg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_pkg
// Shared types, register indexes and reset values for the button click
// gesture detector.
// ----------------------------------------------------------------------------
package bcg_pkg;

  localparam int TIME_WIDTH_DEF = 16;

  localparam int CNT_WIDTH   = 8;
  localparam int DEB_WIDTH   = 15;
  localparam int LONG_WIDTH  = 16;
  localparam int TICK_WIDTH  = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CNT_WIDTH-1:0] CNT_MAX = '1;

  localparam logic                  PRESSED_LEVEL_RST = 1'b1;
  localparam logic [DEB_WIDTH-1:0]  DEBOUNCE_MS_RST   = 15'd150;
  localparam logic [LONG_WIDTH-1:0] LONG_PRESS_MS_RST = 16'd1000;
  localparam logic [TICK_WIDTH-1:0] TICK_MS_RST       = 10'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESSED_LEVEL = 2'd0,
    REG_DEBOUNCE_MS   = 2'd1,
    REG_LONG_PRESS_MS = 2'd2,
    REG_TICK_MS       = 2'd3
  } bcg_reg_t;

  typedef enum logic [1:0] {
    GEST_OTHER   = 2'd0,
    GEST_WAKE    = 2'd1,
    GEST_POWER   = 2'd2,
    GEST_CONFIG  = 2'd3
  } bcg_gesture_t;

  typedef struct packed {
    logic                  pressed_level;
    logic [DEB_WIDTH-1:0]  debounce_ms;
    logic [LONG_WIDTH-1:0] long_press_ms;
    logic [TICK_WIDTH-1:0] tick_ms;
  } bcg_cfg_t;

  typedef struct packed {
    logic                 valid;
    logic [CNT_WIDTH-1:0] clicks;
    logic                 is_long_press;
    logic                 is_long_click;
    bcg_gesture_t         gesture;
  } bcg_evt_t;

endpackage

// ----- design/button_click_gesture_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_gesture_detector
// Debounced button sampler reporting long presses and multi-click sequences.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  in_button_level
//   out      output     out_valid/out_ready  out_clicks, out_is_long_press,
//                                            out_is_long_click, out_gesture
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One sample per clock is accepted while the input register is free or is
// being stepped; a sample is held in the input register, stepped through the
// gesture logic and any event lands in the result register when its sample
// is stepped, and is offered from there.
// A sample that yields an event waits in the input register only while the
// result register is full and not being taken; samples with no event pass.
// Reset (synchronous, rst_n low) restores register defaults and clears state.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
module button_click_gesture_detector import bcg_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_button_level,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CNT_WIDTH-1:0]  out_clicks,
  output logic                  out_is_long_press,
  output logic                  out_is_long_click,
  output logic [1:0]            out_gesture,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bcg_cfg_t cfg_r;

  logic     in_valid_r;
  logic     level_r;
  logic     step;
  bcg_evt_t evt;

  logic                 out_valid_r;
  logic [CNT_WIDTH-1:0] clicks_r;
  logic                 is_long_press_r;
  logic                 is_long_click_r;
  bcg_gesture_t         gesture_r;
  logic                 out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pressed_level <= PRESSED_LEVEL_RST;
      cfg_r.debounce_ms   <= DEBOUNCE_MS_RST;
      cfg_r.long_press_ms <= LONG_PRESS_MS_RST;
      cfg_r.tick_ms       <= TICK_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (bcg_reg_t'(cfg_index))
        REG_PRESSED_LEVEL: cfg_r.pressed_level <= cfg_data[0];
        REG_DEBOUNCE_MS:   cfg_r.debounce_ms   <= cfg_data[DEB_WIDTH-1:0];
        REG_LONG_PRESS_MS: cfg_r.long_press_ms <= cfg_data[LONG_WIDTH-1:0];
        REG_TICK_MS:       cfg_r.tick_ms       <= cfg_data[TICK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // advance the held sample unless its event has nowhere to go
  assign out_free = !out_valid_r || out_ready;
  assign step     = in_valid_r && (out_free || !evt.valid);
  assign in_ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      level_r <= in_button_level;
    end
  end

  bcg_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .level (level_r),
    .cfg   (cfg_r),
    .evt   (evt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step && evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && evt.valid) begin
      clicks_r        <= evt.clicks;
      is_long_press_r <= evt.is_long_press;
      is_long_click_r <= evt.is_long_click;
      gesture_r       <= evt.gesture;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_clicks        = clicks_r;
  assign out_is_long_press = is_long_press_r;
  assign out_is_long_click = is_long_click_r;
  assign out_gesture       = gesture_r;

  a_evt_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
    evt.valid |-> !(evt.is_long_press && evt.is_long_click))
    else $error("event marked both long press and long click");

  a_long_press_gesture: assert property (@(posedge clk) disable iff (!rst_n)
    (evt.valid && evt.is_long_press) |->
      (evt.gesture == GEST_WAKE || evt.gesture == GEST_OTHER))
    else $error("long-press event with switch gesture");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ready && evt.valid))
    else $error("input stalled without a blocked event");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (step && evt.valid) |=> out_valid_r)
    else $error("stepped event did not reach the result register");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !in_valid_r))
    else $error("pipeline not empty after reset");

endmodule

// ----- design/bcg_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_core
// Gesture state (accepted level, timers, long-hold flag, click count) and the
// combinational step logic that produces at most one event per sample.
// ----------------------------------------------------------------------------
module bcg_core import bcg_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  logic     level,
  input  bcg_cfg_t cfg,
  output bcg_evt_t evt
);

  // compare width covers the timer and twice the debounce time, plus a carry
  localparam int CW = ((TIME_WIDTH > DEB_WIDTH + 1) ? TIME_WIDTH : DEB_WIDTH + 1) + 1;
  localparam logic [CW-1:0] TIME_MAX = {{(CW-TIME_WIDTH){1'b0}}, {TIME_WIDTH{1'b1}}};

  logic                  acc_level_r, acc_level_nxt;
  logic [TIME_WIDTH-1:0] deb_timer_r, deb_timer_nxt;
  logic [TIME_WIDTH-1:0] press_timer_r, press_timer_nxt;
  logic                  long_flag_r, long_flag_nxt;
  logic [CNT_WIDTH-1:0]  click_cnt_r, click_cnt_nxt;

  logic                  pressed;
  logic [CW-1:0]         deb_ext;
  logic [CW-1:0]         deb_mid_ext;
  logic [CW-1:0]         deb_sum;
  logic [CW-1:0]         press_sum;
  logic [CW-1:0]         tick_ext;
  logic [TIME_WIDTH-1:0] deb_mid;

  assign pressed  = (level == cfg.pressed_level);
  assign tick_ext = CW'(cfg.tick_ms);
  assign deb_ext  = CW'(deb_timer_r);

  always_comb begin
    acc_level_nxt   = acc_level_r;
    press_timer_nxt = press_timer_r;
    long_flag_nxt   = long_flag_r;
    click_cnt_nxt   = click_cnt_r;
    deb_mid         = deb_timer_r;
    press_sum       = CW'(press_timer_r) + tick_ext;
    evt             = '0;
    evt.gesture     = GEST_OTHER;

    if (level != acc_level_r) begin
      if (pressed && deb_ext >= CW'(cfg.debounce_ms)) begin
        press_timer_nxt = '0;
        acc_level_nxt   = level;
      end
      if (!pressed) begin
        if (click_cnt_r != CNT_MAX) begin
          click_cnt_nxt = click_cnt_r + 1'b1;
        end
        deb_mid       = '0;
        acc_level_nxt = level;
      end
    end else if (pressed) begin
      press_timer_nxt = (press_sum > TIME_MAX) ? TIME_MAX[TIME_WIDTH-1:0]
                                               : press_sum[TIME_WIDTH-1:0];
      if (!long_flag_r && CW'(press_timer_nxt) >= CW'(cfg.long_press_ms)) begin
        long_flag_nxt     = 1'b1;
        evt.valid         = 1'b1;
        evt.clicks        = click_cnt_r;
        evt.is_long_press = 1'b1;
        evt.gesture       = (click_cnt_r == '0) ? GEST_WAKE : GEST_OTHER;
      end
    end

    deb_mid_ext = CW'(deb_mid);

    // end of sequence: released and quiet for twice the debounce time
    if (!pressed && deb_mid_ext >= CW'({cfg.debounce_ms, 1'b0})) begin
      long_flag_nxt = 1'b0;
      if (click_cnt_nxt != '0) begin
        evt.valid         = 1'b1;
        evt.clicks        = click_cnt_nxt;
        evt.is_long_press = 1'b0;
        evt.is_long_click = long_flag_r;
        if (long_flag_r && click_cnt_nxt == CNT_WIDTH'(1)) begin
          evt.gesture = GEST_POWER;
        end else if (long_flag_r && click_cnt_nxt == CNT_WIDTH'(3)) begin
          evt.gesture = GEST_CONFIG;
        end else begin
          evt.gesture = GEST_OTHER;
        end
      end
      click_cnt_nxt = '0;
    end

    deb_sum       = deb_mid_ext + tick_ext;
    deb_timer_nxt = (deb_sum > TIME_MAX) ? TIME_MAX[TIME_WIDTH-1:0]
                                         : deb_sum[TIME_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_level_r   <= ~PRESSED_LEVEL_RST;
      deb_timer_r   <= '0;
      press_timer_r <= '0;
      long_flag_r   <= 1'b0;
      click_cnt_r   <= '0;
    end else if (step) begin
      acc_level_r   <= acc_level_nxt;
      deb_timer_r   <= deb_timer_nxt;
      press_timer_r <= press_timer_nxt;
      long_flag_r   <= long_flag_nxt;
      click_cnt_r   <= click_cnt_nxt;
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the button click gesture detector. Button samples
// are sent as press and release runs shaped around the programmed timing.
// A tracker class predicts long-hold and sequence-end events from each
// accepted sample and matches every event transaction in order. Several
// timing setups are run, from the all-zero corner to the widest values.
// ----------------------------------------------------------------------------
module testbench;
  import bcg_pkg::*;

  localparam int TW = TIME_WIDTH_DEF;

  typedef struct {
    logic [CNT_WIDTH-1:0] clicks;
    logic                 hold_note;
    logic                 hold_end;
    bcg_gesture_t         gesture;
  } gesture_evt_t;

  class gesture_tracker;
    bcg_cfg_t             regs;
    logic                 held_level;
    logic [TW-1:0]        settle_time;
    logic [TW-1:0]        hold_time;
    logic                 long_seen;
    logic [CNT_WIDTH-1:0] click_cnt;
    gesture_evt_t         due_events[$];
    int                   errors;

    function new();
      regs.pressed_level = PRESSED_LEVEL_RST;
      regs.debounce_ms   = DEBOUNCE_MS_RST;
      regs.long_press_ms = LONG_PRESS_MS_RST;
      regs.tick_ms       = TICK_MS_RST;
      held_level  = ~PRESSED_LEVEL_RST;
      settle_time = '0;
      hold_time   = '0;
      long_seen   = 1'b0;
      click_cnt   = '0;
      errors      = 0;
    endfunction

    function logic [TW-1:0] sat_add(logic [TW-1:0] t, logic [TICK_WIDTH-1:0] inc);
      logic [TW:0] s;
      s = t + inc;
      return s[TW] ? {TW{1'b1}} : s[TW-1:0];
    endfunction

    function void write_reg(bcg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PRESSED_LEVEL: regs.pressed_level = data[0];
        REG_DEBOUNCE_MS:   regs.debounce_ms   = data[DEB_WIDTH-1:0];
        REG_LONG_PRESS_MS: regs.long_press_ms = data[LONG_WIDTH-1:0];
        REG_TICK_MS:       regs.tick_ms       = data[TICK_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_events.size();
    endfunction

    // Advance the gesture state by one sample and queue any event it raises.
    function void take_level(logic lvl);
      logic         pressed;
      logic         have;
      gesture_evt_t ev;
      pressed = (lvl == regs.pressed_level);
      have    = 1'b0;
      if (lvl != held_level) begin
        if (pressed && settle_time >= regs.debounce_ms) begin
          hold_time  = '0;
          held_level = lvl;
        end
        if (!pressed) begin
          if (click_cnt != CNT_MAX) click_cnt++;
          settle_time = '0;
          held_level  = lvl;
        end
      end else if (pressed) begin
        hold_time = sat_add(hold_time, regs.tick_ms);
        if (!long_seen && hold_time >= regs.long_press_ms) begin
          long_seen    = 1'b1;
          ev.clicks    = click_cnt;
          ev.hold_note = 1'b1;
          ev.hold_end  = 1'b0;
          ev.gesture   = (click_cnt == 0) ? GEST_WAKE : GEST_OTHER;
          have         = 1'b1;
        end
      end
      // Sequence end looks at the settle time before this tick's increment.
      if (!pressed && settle_time >= {regs.debounce_ms, 1'b0}) begin
        if (click_cnt != 0) begin
          ev.clicks    = click_cnt;
          ev.hold_note = 1'b0;
          ev.hold_end  = long_seen;
          if (long_seen && click_cnt == 1)      ev.gesture = GEST_POWER;
          else if (long_seen && click_cnt == 3) ev.gesture = GEST_CONFIG;
          else                                  ev.gesture = GEST_OTHER;
          have = 1'b1;
        end
        long_seen = 1'b0;
        click_cnt = '0;
      end
      settle_time = sat_add(settle_time, regs.tick_ms);
      if (have) due_events.push_back(ev);
    endfunction

    function void match_event(logic [CNT_WIDTH-1:0] clicks, logic lp, logic lc,
                              logic [1:0] g);
      gesture_evt_t ev;
      if (due_events.size() == 0) begin
        $error("event with none expected: clicks %0d is_long_press %0b", clicks, lp);
        errors++;
        return;
      end
      ev = due_events.pop_front();
      if (clicks !== ev.clicks) begin
        $error("clicks: expected %0d, got %0d", ev.clicks, clicks);
        errors++;
      end
      if (lp !== ev.hold_note) begin
        $error("is_long_press: expected %0b, got %0b", ev.hold_note, lp);
        errors++;
      end
      if (lc !== ev.hold_end) begin
        $error("is_long_click: expected %0b, got %0b", ev.hold_end, lc);
        errors++;
      end
      if (g !== ev.gesture) begin
        $error("gesture: expected %0d, got %0d", ev.gesture, g);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_button_level;
  logic                  out_valid;
  logic                  out_ready;
  logic [CNT_WIDTH-1:0]  out_clicks;
  logic                  out_is_long_press;
  logic                  out_is_long_click;
  logic [1:0]            out_gesture;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gesture_tracker tracker;
  bit             send_calm;
  bit             hold_off;

  button_click_gesture_detector dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_button_level   (in_button_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_clicks        (out_clicks),
    .out_is_long_press (out_is_long_press),
    .out_is_long_click (out_is_long_click),
    .out_gesture       (out_gesture),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // Offer one sample after a random gap and hold it until the transaction.
  task automatic send_level(logic lvl);
    int gap;
    if ($urandom_range(0, 63) == 0) send_calm = ~send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_button_level <= lvl;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.take_level(lvl);
    @(negedge clk);
  endtask

  task automatic send_run(logic lvl, int n);
    repeat (n) send_level(lvl);
  endtask

  task automatic cfg_write(bcg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Let every expected event drain, then reprogram all configuration registers.
  task automatic load_timing(logic pl, int deb, int hold, int tick);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_write(REG_PRESSED_LEVEL, CFG_DATA_W'(pl));
    cfg_write(REG_DEBOUNCE_MS, CFG_DATA_W'(deb));
    cfg_write(REG_LONG_PRESS_MS, CFG_DATA_W'(hold));
    cfg_write(REG_TICK_MS, CFG_DATA_W'(tick));
  endtask

  // Mostly press/release runs sized to the current timing, some noise.
  task automatic run_random(int count);
    int   sent;
    int   tick;
    int   deb_t;
    int   hold_t;
    int   len;
    logic p;
    p      = tracker.regs.pressed_level;
    tick   = (tracker.regs.tick_ms == 0) ? 1 : int'(tracker.regs.tick_ms);
    deb_t  = (int'(tracker.regs.debounce_ms) + tick - 1) / tick;
    if (deb_t < 1) deb_t = 1;
    hold_t = (int'(tracker.regs.long_press_ms) + tick - 1) / tick + 1;
    sent   = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 6);
        repeat (len) send_level(1'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 2) == 0) len = $urandom_range(hold_t, hold_t + 2);
        else                           len = $urandom_range(1, 3);
        send_run(p, len);
        sent += len;
        if ($urandom_range(0, 2) == 0) len = $urandom_range(2 * deb_t + 1, 2 * deb_t + 8);
        else                           len = $urandom_range(1, deb_t + 1);
        send_run(~p, len);
      end
      sent += len;
    end
  endtask

  initial begin : event_sink
    int stall;
    bit calm;
    out_ready = 1'b0;
    calm      = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) calm = ~calm;
      stall = calm ? 0 : $urandom_range(0, 3);
      if (hold_off) begin
        stall    = 300;
        hold_off = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      tracker.match_event(out_clicks, out_is_long_press, out_is_long_click, out_gesture);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int wait_cycles;
    tracker         = new();
    send_calm       = 1'b0;
    hold_off        = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_button_level = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_PRESSED_LEVEL;
    cfg_data        = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Short timing: debounce one tick, long hold three ticks.
    load_timing(1'b1, 10, 30, 10);
    send_run(1'b0, 1);
    send_run(1'b1, 4);  // long hold with no clicks: wake
    send_run(1'b0, 3);  // one long click: power switch
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 4);  // hold during the third press
    send_run(1'b0, 3);  // three clicks ending long: config switch
    send_run(1'b1, 2);
    send_run(1'b0, 3);  // plain single click

    // Stall the event side so the block backs up into its input.
    hold_off = 1'b1;
    run_random(250);

    // Active-low button while the held level is left as it was.
    load_timing(1'b0, 25, 70, 10);
    run_random(250);

    load_timing(1'b1, 1, 1, 1);
    run_random(200);

    // Drive the click count into saturation.
    load_timing(1'b1, 10, 65535, 10);
    send_run(1'b0, 4);
    repeat (270) begin
      send_level(1'b1);
      send_level(1'b0);
    end
    send_run(1'b0, 4);

    // Widest timing: both timers reach saturation.
    load_timing(1'b0, 30000, 65535, 1000);
    run_random(300);

    load_timing(1'b1, 150, 1000, 10);
    run_random(300);

    // Zero tick freezes the timers; zero thresholds pass at once.
    load_timing(1'b1, 0, 0, 0);
    run_random(100);

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (tracker.pending() != 0 && wait_cycles < 4000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (8) @(negedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d expected events never arrived", tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
